// ----- rtl/dkc_pkg.sv -----
// Shared constants, field widths, operation codes and the result word type
// for the k-mer counter. No dependencies.
package dkc_pkg;

  localparam int MAX_KMER_LENGTH_DEF = 8;

  localparam int KLEN_W      = 4;
  localparam int BASE_W      = 3;
  localparam int ADDR_IN_W   = 16;
  localparam int INDEX_W     = 16;
  localparam int COUNT_W     = 32;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_QDEPTH  = 3;

  localparam logic [KLEN_W-1:0]  KLEN_RESET = 4'd8;
  localparam logic [BASE_W-1:0]  N_CODE     = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  localparam logic KIND_BASE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

// ----- rtl/dkc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/dkc_window.sv -----
// Base window and run length; forms the table index and operation of each word.
// Depends on dkc_pkg.
module dkc_window #(
  parameter int MAX_LEN = dkc_pkg::MAX_KMER_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dkc_pkg::KLEN_W-1:0]    klen,
  input  logic                          fire,
  input  logic                          kind,
  input  logic [dkc_pkg::BASE_W-1:0]    base,
  input  logic                          row_start,
  input  logic [dkc_pkg::ADDR_IN_W-1:0] address,
  output dkc_pkg::op_t                  op,
  output logic [2*MAX_LEN-1:0]          idx
);
  import dkc_pkg::*;

  localparam int WIN_W = 2 * MAX_LEN;
  localparam int RUN_W = $clog2(MAX_LEN + 1);

  logic [WIN_W-1:0]  window_r, window_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt, run_base;
  logic [KLEN_W-1:0] k_eff;
  logic [WIN_W+1:0]  win_shift;
  logic [WIN_W-1:0]  len_mask;

  always_comb begin
    priority if (klen == '0) begin
      k_eff = KLEN_W'(1);
    end else if (klen > KLEN_W'(MAX_LEN)) begin
      k_eff = KLEN_W'(MAX_LEN);
    end else begin
      k_eff = klen;
    end
    for (int j = 0; j < WIN_W; j++) begin
      len_mask[j] = ((j >> 1) < int'(k_eff));
    end
    run_base   = row_start ? '0 : run_r;
    win_shift  = {window_r, base[1:0]};
    window_nxt = window_r;
    run_nxt    = run_r;
    op         = OP_NONE;
    idx        = '0;
    if (kind == KIND_READ) begin
      op  = OP_READ;
      idx = WIN_W'(address);
    end else if (base >= N_CODE) begin
      run_nxt = '0;
    end else begin
      window_nxt = win_shift[WIN_W-1:0];
      run_nxt    = (run_base == RUN_W'(MAX_LEN)) ? run_base : run_base + RUN_W'(1);
      idx        = window_nxt & len_mask;
      op         = (KLEN_W'(run_nxt) >= k_eff) ? OP_COUNT : OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      run_r    <= '0;
    end else if (fire) begin
      window_r <= window_nxt;
      run_r    <= run_nxt;
    end
  end

endmodule

// ----- rtl/dkc_rmw.sv -----
// Count table read-modify-write stage with write forwarding and the clearing
// sweep after reset. Depends on dkc_pkg and dkc_ram.
module dkc_rmw #(
  parameter int MAX_LEN = dkc_pkg::MAX_KMER_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s0_fire,
  input  dkc_pkg::op_t         s0_op,
  input  logic [2*MAX_LEN-1:0] s0_idx,
  output logic                 busy,
  output logic                 s1_push,
  output dkc_pkg::res_t        s1_res
);
  import dkc_pkg::*;

  localparam int AW    = 2 * MAX_LEN;
  localparam int DEPTH = 1 << AW;

  logic          clr_r;
  logic [AW-1:0] clr_addr_r;

  logic          s1_valid_r;
  op_t           s1_op_r;
  logic [AW-1:0] s1_idx_r;

  logic               lw_valid_r;
  logic [AW-1:0]      lw_idx_r;
  logic [COUNT_W-1:0] lw_data_r;

  logic [COUNT_W-1:0] rd_data, cur, upd;
  logic               upd_we, ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;

  dkc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s0_idx),
    .rdata (rd_data)
  );

  always_comb begin
    cur    = (lw_valid_r && lw_idx_r == s1_idx_r) ? lw_data_r : rd_data;
    upd    = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);
    upd_we = s1_valid_r && s1_op_r == OP_COUNT;
    if (clr_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = s1_idx_r;
      ram_wdata = upd;
    end
    s1_res = '0;
    unique case (s1_op_r)
      OP_COUNT: begin
        s1_res.valid = 1'b1;
        s1_res.index = INDEX_W'(s1_idx_r);
        s1_res.count = upd;
      end
      OP_READ: begin
        s1_res.valid = 1'b1;
        s1_res.index = INDEX_W'(s1_idx_r);
        s1_res.count = cur;
      end
      OP_NONE: begin
        s1_res = '0;
      end
      default: begin
        s1_res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
      lw_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == '1) begin
          clr_r <= 1'b0;
        end
      end
      s1_valid_r <= s0_fire;
      if (upd_we) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      s1_op_r  <= s0_op;
      s1_idx_r <= s0_idx;
    end
    if (upd_we) begin
      lw_idx_r  <= s1_idx_r;
      lw_data_r <= upd;
    end
  end

  assign busy    = clr_r;
  assign s1_push = s1_valid_r;

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !s1_valid_r && !s0_fire)
    else $error("item in flight during table clear");

  a_clear_ends_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_r) |-> $past(clr_addr_r) == '1)
    else $error("table clear ended early");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    upd_we |-> upd != '0 && ram_waddr == s1_idx_r)
    else $error("counted word wrote a zero count or wrong entry");

endmodule

// ----- rtl/dkc_out_queue.sv -----
// Small result queue that decouples the table pipeline from the output stall.
// Depends on dkc_pkg.
module dkc_out_queue (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  dkc_pkg::res_t                          push_res,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output dkc_pkg::res_t                          out_res,
  output logic [$clog2(dkc_pkg::OUT_QDEPTH+1)-1:0] count
);
  import dkc_pkg::*;

  localparam int CNT_W = $clog2(OUT_QDEPTH + 1);
  localparam int PTR_W = $clog2(OUT_QDEPTH);

  res_t             entry_r [OUT_QDEPTH];
  logic [PTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_res   = entry_r[head_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        tail_r <= (tail_r == PTR_W'(OUT_QDEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
      end
      if (pop) begin
        head_r <= (head_r == PTR_W'(OUT_QDEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[tail_r] <= push_res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != CNT_W'(OUT_QDEPTH))
    else $error("result queue overflow");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("result queue count lost a word");

  a_pointers_agree: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 || cnt_r == CNT_W'(OUT_QDEPTH) |-> head_r == tail_r)
    else $error("result queue pointers out of step");

endmodule

// ----- rtl/dna_kmer_counter.sv -----
// Top level of the k-mer counter: config register, window, table update, queue.
// Depends on dkc_pkg, dkc_window, dkc_rmw, dkc_out_queue.
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  cfg     | cfg_valid / cfg_ready   | cfg_data = kmer_length
//  in      | in_tvalid / in_tready   | tuser = kind; tdata = base,row_start,address
//  out     | out_tvalid / out_tready | tuser = kmer_valid; tdata = kmer_index,count
//
// One word per cycle while in_tready is high; a result is registered in the table stage and
// then in the result queue before it is offered. The table memory does one read and one write
// a cycle; the write of the previous word is forwarded to the next one when both hit the same
// entry. After reset a clear sweep writes every entry, 4**MAX_KMER_LENGTH of them (65536 by
// default), with in_tready low; cfg writes are taken throughout. A three-word result queue
// absorbs output stalls; in_tready falls when its words plus the one in flight reach three.
module dna_kmer_counter #(
  parameter int MAX_KMER_LENGTH = dkc_pkg::MAX_KMER_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dkc_pkg::KLEN_W-1:0]      cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dkc_pkg::IN_TDATA_W-1:0]  in_tdata,   // base[2:0], row_start[3], address[19:4]
  input  logic                            in_tuser,   // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dkc_pkg::OUT_TDATA_W-1:0] out_tdata,  // kmer_index[15:0], count[47:16]
  output logic                            out_tuser   // kmer_valid
);
  import dkc_pkg::*;

  localparam int AW    = 2 * MAX_KMER_LENGTH;
  localparam int CNT_W = $clog2(OUT_QDEPTH + 1);

  logic [KLEN_W-1:0] klen_r;
  logic              fire, busy, s1_push;
  op_t               s0_op;
  logic [AW-1:0]     s0_idx;
  res_t              s1_res, q_res;
  logic [CNT_W-1:0]  q_count;
  logic [CNT_W:0]    occ;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      klen_r <= cfg_data;
    end
  end

  assign occ       = {1'b0, q_count} + {{CNT_W{1'b0}}, s1_push};
  assign in_tready = !busy && (occ < (CNT_W + 1)'(OUT_QDEPTH));
  assign fire      = in_tvalid && in_tready;

  dkc_window #(
    .MAX_LEN (MAX_KMER_LENGTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .klen      (klen_r),
    .fire      (fire),
    .kind      (in_tuser),
    .base      (in_tdata[BASE_W-1:0]),
    .row_start (in_tdata[BASE_W]),
    .address   (in_tdata[BASE_W+ADDR_IN_W:BASE_W+1]),
    .op        (s0_op),
    .idx       (s0_idx)
  );

  dkc_rmw #(
    .MAX_LEN (MAX_KMER_LENGTH)
  ) u_rmw (
    .clk     (clk),
    .rst_n   (rst_n),
    .s0_fire (fire),
    .s0_op   (s0_op),
    .s0_idx  (s0_idx),
    .busy    (busy),
    .s1_push (s1_push),
    .s1_res  (s1_res)
  );

  dkc_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_push),
    .push_res  (s1_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (q_res),
    .count     (q_count)
  );

  assign out_tdata = {q_res.count, q_res.index};
  assign out_tuser = q_res.valid;

endmodule
